// ===== sv/assert_macros.svh =====
// Assertion macros shared by the hexagonal cell migration RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition holds, so consequence holds in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Condition holds, so consequence holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Condition never holds.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== sv/hlcm_pkg.sv =====
// Shared types and constants of the hexagonal cell migration block.
`timescale 1ns / 1ps

package hlcm_pkg;

    localparam int WORD_W  = 144;
    localparam int USER_W  = 2;
    localparam int CFG_W   = 31;
    localparam int IDX_W   = 2;
    localparam int MAG_W   = 33;

    // sqrt(3) in unsigned Q1.30
    localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;

    // Output tuser bit positions
    localparam int USER_MOVED = 0;
    localparam int USER_FAR   = 1;

    typedef enum logic [IDX_W-1:0] {
        REG_CELL_HALF_HEIGHT = 2'd0,
        REG_INDEX_SCALE      = 2'd1,
        REG_X_LATTICE_STEP   = 2'd2,
        REG_Y_LATTICE_STEP   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] y_lattice_step;
        logic [CFG_W-1:0] x_lattice_step;
        logic [CFG_W-1:0] index_scale;
        logic [CFG_W-1:0] cell_half_height;
    } t_cfg;

    // Coordinates and hop count, x in the lowest bits (same layout as tdata)
    typedef struct packed {
        logic        [15:0] hops;
        logic signed [31:0] oy;
        logic signed [31:0] ox;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } t_pay;

    // Classified item handed from the front to the back
    typedef struct packed {
        t_pay                   pay;
        logic                   mig;
        logic                   far;
        logic [2:0][MAG_W-1:0]  mag;
        logic [2:0]             neg;
    } t_task;

endpackage

// ===== sv/hex_lattice_cell_migration.sv =====
// Top level of the hexagonal lattice cell migration block.
//
//  channel   | direction | handshake               | contents
//  s_axis    | in        | tvalid / tready         | tdata: position, cell centre, hop count
//  m_axis    | out       | tvalid / tready         | tdata: new position, centre, hops; tuser
//  cfg       | in        | i_cfg_valid/o_cfg_ready | register index, 31-bit value
//
// One word per cycle sustained while m_axis is ready; a word taken passes through
// 4 front stages, one queue slot, 7 back stages and the result register to m_axis.
// Reset clears all valid bits and the queue and loads 1.0 into every register.
// A stalled m_axis freezes the back; the front keeps taking words until the
// QUEUE_DEPTH-entry queue fills. Configuration writes are taken every cycle.
`timescale 1ns / 1ps

module hex_lattice_cell_migration #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // pos_x, pos_y, origin_x, origin_y, hops_in
    input  logic [hlcm_pkg::WORD_W-1:0] i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // new_pos_x, new_pos_y, new_origin_x, new_origin_y, hops_out
    output logic [hlcm_pkg::WORD_W-1:0] o_m_axis_tdata,
    // moved, far_jump
    output logic [hlcm_pkg::USER_W-1:0] o_m_axis_tuser,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [hlcm_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [hlcm_pkg::CFG_W-1:0]  i_cfg_data
);

    hlcm_pkg::t_cfg  r_cfg;
    hlcm_pkg::t_task w_f_task;
    hlcm_pkg::t_task w_q_task;
    logic            w_f_valid;
    logic            w_f_ready;
    logic            w_q_valid;
    logic            w_q_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cell_half_height <= 31'd65536;
            r_cfg.index_scale      <= 31'd65536;
            r_cfg.x_lattice_step   <= 31'd65536;
            r_cfg.y_lattice_step   <= 31'd65536;
        end else if (i_cfg_valid) begin
            case (hlcm_pkg::t_reg_idx'(i_cfg_index))
                hlcm_pkg::REG_CELL_HALF_HEIGHT: r_cfg.cell_half_height <= i_cfg_data;
                hlcm_pkg::REG_INDEX_SCALE:      r_cfg.index_scale      <= i_cfg_data;
                hlcm_pkg::REG_X_LATTICE_STEP:   r_cfg.x_lattice_step   <= i_cfg_data;
                hlcm_pkg::REG_Y_LATTICE_STEP:   r_cfg.y_lattice_step   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hlcm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_task  (w_f_task)
    );

    hlcm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_task),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_task)
    );

    hlcm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_task  (w_q_task),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_user  (o_m_axis_tuser)
    );

endmodule

// ===== sv/hlcm_front.sv =====
// Front pipeline: hexagonal projections, magnitudes and the migration test.
`timescale 1ns / 1ps

module hlcm_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hlcm_pkg::t_cfg              i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [hlcm_pkg::WORD_W-1:0] i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output hlcm_pkg::t_task             o_task
);

    logic [3:0]              r_v;
    logic                    en;
    hlcm_pkg::t_pay          w_in;
    hlcm_pkg::t_pay          r1_pay;
    hlcm_pkg::t_pay          r2_pay;
    hlcm_pkg::t_pay          r3_pay;
    logic signed [63:0]      r1_prod;
    logic signed [63:0]      w_rnd;
    logic signed [33:0]      w_hs;
    logic signed [33:0]      w_y;
    logic signed [33:0]      w_h [3];
    logic signed [33:0]      r2_h [3];
    logic signed [33:0]      w_neg [3];
    logic [hlcm_pkg::MAG_W-1:0] r3_mag [3];
    logic [2:0]              r3_neg;
    logic [hlcm_pkg::MAG_W-1:0] w_m01;
    logic [hlcm_pkg::MAG_W-1:0] w_max;
    hlcm_pkg::t_task         r4_task;

    // Whole pipeline advances together; hold while the last stage holds a word the queue refuses.
    assign en      = !r_v[3] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[3];
    assign o_task  = r4_task;
    assign w_in    = hlcm_pkg::t_pay'(i_data);

    always_comb begin
        // sqrt3*x rounded half up to Q16.16
        w_rnd   = r1_prod + 64'sd536870912;
        w_hs    = w_rnd[63:30];
        w_y     = {{2{r1_pay.y[31]}}, r1_pay.y};
        w_h[0]  = w_y + w_hs;
        w_h[1]  = w_y - w_hs;
        w_h[2]  = 34'sd0 - {w_y[32:0], 1'b0};
        for (int k = 0; k < 3; k++) begin
            w_neg[k] = 34'sd0 - r2_h[k];
        end
        w_m01 = (r3_mag[0] > r3_mag[1]) ? r3_mag[0] : r3_mag[1];
        w_max = (w_m01 > r3_mag[2]) ? w_m01 : r3_mag[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_prod <= $signed(w_in.x) * $signed({1'b0, hlcm_pkg::SQRT3_Q30});
            r1_pay  <= w_in;

            r2_h    <= w_h;
            r2_pay  <= r1_pay;

            for (int k = 0; k < 3; k++) begin
                r3_mag[k] <= r2_h[k][33] ? w_neg[k][32:0] : r2_h[k][32:0];
                r3_neg[k] <= r2_h[k][33];
            end
            r3_pay  <= r2_pay;

            r4_task.pay <= r3_pay;
            r4_task.mig <= w_max > {2'b00, i_cfg.cell_half_height};
            r4_task.far <= w_max > {1'b0, i_cfg.cell_half_height, 1'b0};
            for (int k = 0; k < 3; k++) begin
                r4_task.mag[k] <= r3_mag[k];
            end
            r4_task.neg <= r3_neg;
        end
    end

endmodule

// ===== sv/hlcm_fifo.sv =====
// Short queue of classified words between the front and the back.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hlcm_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  hlcm_pkg::t_task i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output hlcm_pkg::t_task o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hlcm_pkg::t_task r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic [AW-1:0]   n_wr;
    logic [AW-1:0]   n_rd;
    logic [CW-1:0]   n_cnt;
    logic            push;
    logic            pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt > CW'(DEPTH))
    `ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, push && !pop, r_cnt == CW'($past(r_cnt) + 1'b1))
    `ASSERT_IMPL(a_empty_aligned, i_clk, i_rst_n, r_cnt == '0, r_wr == r_rd)

endmodule

// ===== sv/hlcm_back.sv =====
// Back pipeline: lattice indices, modulo 3 correction, lattice shift and saturation.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hlcm_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hlcm_pkg::t_cfg              i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  hlcm_pkg::t_task             i_task,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hlcm_pkg::WORD_W-1:0] o_data,
    output logic [hlcm_pkg::USER_W-1:0] o_user
);

    typedef struct packed {
        hlcm_pkg::t_pay pay;
        logic           mig;
        logic           far;
    } t_carry;

    logic [6:0]          r_v;
    logic                r_ov;
    logic                en;
    t_carry              r_car [7];
    logic [63:0]         r1_m [3];
    logic [2:0]          r1_neg;
    logic signed [34:0]  r2_n [3];
    logic signed [35:0]  r3_d;
    logic signed [35:0]  r3_s;
    logic signed [36:0]  r3_t;
    logic [1:0]          r4_r;
    logic signed [35:0]  r4_d;
    logic signed [35:0]  r4_s;
    logic signed [36:0]  r4_t;
    logic signed [38:0]  w_dn;
    logic signed [38:0]  w_sn;
    logic signed [33:0]  r5_dn;
    logic signed [33:0]  r5_sn;
    logic signed [65:0]  r6_px;
    logic signed [65:0]  r6_py;
    logic signed [41:0]  r7_sx;
    logic signed [41:0]  r7_sy;
    logic signed [42:0]  w_nx;
    logic signed [42:0]  w_ny;
    logic signed [42:0]  w_nox;
    logic signed [42:0]  w_noy;
    hlcm_pkg::t_pay      w_res;
    hlcm_pkg::t_pay      r_out_pay;
    logic [hlcm_pkg::USER_W-1:0] r_out_user;

    // round(|h|*scale + 1/2) with halves away from zero, sign applied
    function automatic logic signed [34:0] lat_index(input logic [63:0] m, input logic neg);
        logic signed [34:0] hi;
        hi = {3'b000, m[63:32]};
        if (!neg) begin
            lat_index = hi + 35'sd1;
        end else if (m[63:31] != '0) begin
            lat_index = -hi;
        end else if (m == '0) begin
            lat_index = 35'sd1;
        end else begin
            lat_index = '0;
        end
    endfunction

    // Residue modulo 3 of a signed word: base-4 digit sums, 2^36 folds to 1
    function automatic logic [1:0] mod3_36(input logic [35:0] v);
        logic [3:0] grp [6];
        logic [5:0] acc;
        logic [3:0] a;
        logic [2:0] b;
        for (int g = 0; g < 6; g++) begin
            grp[g] = 4'(v[6*g +: 2]) + 4'(v[6*g+2 +: 2]) + 4'(v[6*g+4 +: 2]);
        end
        acc = {4'b0000, v[35], 1'b0};
        for (int g = 0; g < 6; g++) begin
            acc = acc + 6'(grp[g]);
        end
        a = 4'(acc[1:0]) + 4'(acc[3:2]) + 4'(acc[5:4]);
        b = 3'(a[1:0]) + 3'(a[3:2]);
        mod3_36 = (b >= 3'd3) ? 2'(b - 3'd3) : b[1:0];
    endfunction

    function automatic logic signed [33:0] clamp_idx(input logic signed [38:0] v);
        if (v > 39'sd4294967296) begin
            clamp_idx = 34'sd4294967296;
        end else if (v < -39'sd4294967296) begin
            clamp_idx = -34'sd4294967296;
        end else begin
            clamp_idx = v[33:0];
        end
    endfunction

    function automatic logic signed [41:0] clamp_shift(input logic signed [65:0] v);
        if (v > 66'sd1099511627776) begin
            clamp_shift = 42'sd1099511627776;
        end else if (v < -66'sd1099511627776) begin
            clamp_shift = -42'sd1099511627776;
        end else begin
            clamp_shift = v[41:0];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        if (v > 43'sd2147483647) begin
            sat32 = 32'sh7FFFFFFF;
        end else if (v < -43'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    // Freeze every stage while the result register is full and not taken.
    assign en      = !r_ov || i_ready;
    assign o_ready = en;
    assign o_valid = r_ov;
    assign o_data  = r_out_pay;
    assign o_user  = r_out_user;

    always_comb begin
        // Residue 0 moves both indices by the index sum less one; 1 or 2 drop one index.
        case (r4_r)
            2'd0: begin
                w_dn = 39'(r4_d);
                w_sn = 39'(r4_s) - (39'(r4_t) <<< 1);
            end
            2'd1: begin
                w_dn = 39'(r4_d) - 39'sd1;
                w_sn = 39'(r4_s) - 39'sd1;
            end
            default: begin
                w_dn = 39'(r4_d) + 39'sd1;
                w_sn = 39'(r4_s) - 39'sd1;
            end
        endcase

        w_nx  = 43'(r_car[6].pay.x)  - 43'(r7_sx);
        w_nox = 43'(r_car[6].pay.ox) + 43'(r7_sx);
        w_ny  = 43'(r_car[6].pay.y)  - 43'(r7_sy);
        w_noy = 43'(r_car[6].pay.oy) + 43'(r7_sy);

        w_res.x  = sat32(w_nx);
        w_res.y  = sat32(w_ny);
        w_res.ox = sat32(w_nox);
        w_res.oy = sat32(w_noy);
        w_res.hops = (r_car[6].mig && (r_car[6].pay.hops != 16'hFFFF))
                   ? r_car[6].pay.hops + 16'd1 : r_car[6].pay.hops;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v  <= {r_v[5:0], i_valid};
            r_ov <= r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_car[0].pay <= i_task.pay;
            r_car[0].mig <= i_task.mig;
            r_car[0].far <= i_task.far;
            for (int k = 1; k < 7; k++) begin
                r_car[k] <= r_car[k-1];
            end

            for (int k = 0; k < 3; k++) begin
                r1_m[k] <= i_task.mag[k] * i_cfg.index_scale;
                r2_n[k] <= lat_index(r1_m[k], r1_neg[k]);
            end
            r1_neg <= i_task.neg;

            r3_d <= 36'(r2_n[0]) - 36'(r2_n[1]);
            r3_s <= 36'(r2_n[0]) + 36'(r2_n[1]);
            r3_t <= 37'(r2_n[0]) + 37'(r2_n[1]) + 37'(r2_n[2]) - 37'sd1;

            r4_r <= mod3_36(r3_d);
            r4_d <= r3_d;
            r4_s <= r3_s;
            r4_t <= r3_t;

            r5_dn <= clamp_idx(w_dn);
            r5_sn <= clamp_idx(w_sn);

            r6_px <= r5_dn * $signed({1'b0, i_cfg.x_lattice_step});
            r6_py <= r5_sn * $signed({1'b0, i_cfg.y_lattice_step});

            // A word that stays in its cell gets no shift.
            r7_sx <= r_car[5].mig ? clamp_shift(r6_px) : '0;
            r7_sy <= r_car[5].mig ? clamp_shift(r6_py) : '0;

            r_out_pay <= w_res;
            r_out_user[hlcm_pkg::USER_MOVED] <= r_car[6].mig;
            r_out_user[hlcm_pkg::USER_FAR]   <= r_car[6].far;
        end
    end

    `ASSERT_IMPL(a_far_moved, i_clk, i_rst_n, r_ov && r_out_user[hlcm_pkg::USER_FAR], r_out_user[hlcm_pkg::USER_MOVED])
    `ASSERT_IMPL(a_hops_moved, i_clk, i_rst_n, r_ov && r_out_user[hlcm_pkg::USER_MOVED], r_out_pay.hops != 16'd0)
    `ASSERT_NEXT(a_pop_loads, i_clk, i_rst_n, i_valid && en, r_v[0])

endmodule

// ===== tb/sv/hex_lattice_cell_migration_tb.sv =====
// Self-checking bench for the hexagonal lattice cell migration block.
`timescale 1ns / 1ps

module hex_lattice_cell_migration_tb;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic           moved;
        logic           far;
        hlcm_pkg::t_pay pay;
    } t_cell_update;

    localparam t_wide ROOT3_Q30  = 128'sd1859775393;
    localparam t_wide ROUND_Q30  = 128'sh2000_0000;
    localparam t_wide HALF_Q32   = 128'sh8000_0000;
    localparam t_wide ONE_Q32    = 128'sh1_0000_0000;
    localparam t_wide SHIFT_LIM  = 128'sh100_0000_0000;
    localparam t_wide SAT_HI     = 128'sh7FFF_FFFF;
    localparam t_wide SAT_LO     = -SAT_HI - 1;
    localparam int    CMAX       = 2147483647;
    localparam int    CMIN       = -2147483647 - 1;
    localparam int    ONE        = 65536;
    localparam int    PHASES     = 9;
    localparam int    RANDOM_PER = 66;
    localparam int    IDLE_LIMIT = 2000;
    localparam int    PRINT_CAP  = 60;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [hlcm_pkg::WORD_W-1:0]   i_s_axis_tdata = '0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    logic [hlcm_pkg::WORD_W-1:0]   o_m_axis_tdata;
    logic [hlcm_pkg::USER_W-1:0]   o_m_axis_tuser;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [hlcm_pkg::IDX_W-1:0]    i_cfg_index = '0;
    logic [hlcm_pkg::CFG_W-1:0]    i_cfg_data = '0;

    // model copy of the register file
    t_wide half_height_cfg = 65536;
    t_wide index_scale_cfg = 65536;
    t_wide x_step_cfg      = 65536;
    t_wide y_step_cfg      = 65536;

    hlcm_pkg::t_pay particle_q[$];
    t_cell_update   expected_cells[$];

    logic           calm = 1'b0;
    logic           word_taken = 1'b0;
    int unsigned    feed_gap = 0;
    int unsigned    stall_left = 0;
    int unsigned    idle_cycles = 0;
    int unsigned    errors = 0;
    int unsigned    words_in = 0;
    int unsigned    results_out = 0;
    int unsigned    moves_seen = 0;
    int unsigned    far_seen = 0;
    t_cell_update   want;
    hlcm_pkg::t_pay got;

    hex_lattice_cell_migration dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_wide magnitude(t_wide v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_wide clamp(t_wide v, t_wide lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic logic [31:0] saturate(t_wide v);
        if (v > SAT_HI) return 32'h7FFF_FFFF;
        if (v < SAT_LO) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // round(h * scale + 1/2), halves away from zero
    function automatic t_wide lattice_index(t_wide h);
        t_wide m;
        m = magnitude(h) * index_scale_cfg;
        if (h >= 0) return (m + ONE_Q32) >>> 32;
        if (m >= HALF_Q32) return -(m >>> 32);
        return (ONE_Q32 - m) >>> 32;
    endfunction

    function automatic t_cell_update migrate_cell(hlcm_pkg::t_pay p);
        t_wide x, y, ox, oy, hs, h1, h2, h3, hm;
        t_wide n1, n2, n3, r, dn, sn, sx, sy;
        logic [15:0] hops;
        t_cell_update c;
        x  = $signed(p.x);
        y  = $signed(p.y);
        ox = $signed(p.ox);
        oy = $signed(p.oy);
        hops = p.hops;
        hs = (x * ROOT3_Q30 + ROUND_Q30) >>> 30;
        h1 = y + hs;
        h2 = y - hs;
        h3 = -y - y;
        hm = magnitude(h1);
        if (magnitude(h2) > hm) hm = magnitude(h2);
        if (magnitude(h3) > hm) hm = magnitude(h3);
        c.moved = hm > half_height_cfg;
        c.far   = c.moved && (hm > 2 * half_height_cfg);
        if (c.moved) begin
            n1 = lattice_index(h1);
            n2 = lattice_index(h2);
            n3 = lattice_index(h3);
            n3 = n1 + n2 + n3 - 1;
            // pick the lattice site whose index difference is a multiple of 3
            r = (n1 - n2) % 3;
            if (r == 0) begin
                n1 = n1 - n3;
                n2 = n2 - n3;
            end else if (r == 1 || r == -2) begin
                n1 = n1 - 1;
            end else begin
                n2 = n2 - 1;
            end
            dn = clamp(n1 - n2, ONE_Q32);
            sn = clamp(n1 + n2, ONE_Q32);
            sx = clamp(dn * x_step_cfg, SHIFT_LIM);
            sy = clamp(sn * y_step_cfg, SHIFT_LIM);
            x  = x - sx;
            ox = ox + sx;
            y  = y - sy;
            oy = oy + sy;
            if (hops != 16'hFFFF) hops = hops + 16'd1;
        end
        c.pay.x    = saturate(x);
        c.pay.y    = saturate(y);
        c.pay.ox   = saturate(ox);
        c.pay.oy   = saturate(oy);
        c.pay.hops = hops;
        return c;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 85) return $urandom_range(3, 1);
        if (p < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic hlcm_pkg::t_pay particle(int x, int y, int ox, int oy, int hops);
        hlcm_pkg::t_pay p;
        p.x    = x;
        p.y    = y;
        p.ox   = ox;
        p.oy   = oy;
        p.hops = hops[15:0];
        return p;
    endfunction

    // mostly near the current threshold, some full range, some near zero, some near the rails
    function automatic logic [31:0] random_coord();
        int unsigned reach;
        t_wide v;
        if (half_height_cfg > 128'sh2AAA_AAAA)
            reach = 32'h7FFF_FFFF;
        else
            reach = 32'(3 * half_height_cfg + 256);
        case ($urandom_range(9))
            0, 1: return $urandom();
            2: begin
                v = $urandom_range(255);
                if ($urandom_range(1)) return 32'(SAT_HI - v);
                return 32'(SAT_LO + v);
            end
            3: begin
                v = $urandom_range(511);
                return 32'(v - 256);
            end
            default: begin
                v = $urandom_range(reach);
                if ($urandom_range(1)) v = -v;
                return v[31:0];
            end
        endcase
    endfunction

    function automatic hlcm_pkg::t_pay random_particle();
        hlcm_pkg::t_pay p;
        p.x  = random_coord();
        p.y  = random_coord();
        p.ox = random_coord();
        p.oy = random_coord();
        case ($urandom_range(7))
            0: p.hops = 16'h0000;
            1: p.hops = 16'hFFFE;
            2: p.hops = 16'hFFFF;
            default: p.hops = 16'($urandom());
        endcase
        return p;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            // keep the log short when many words go wrong
            if (errors <= PRINT_CAP)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    task automatic write_reg(hlcm_pkg::t_reg_idx idx, logic [hlcm_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            hlcm_pkg::REG_CELL_HALF_HEIGHT: half_height_cfg = val;
            hlcm_pkg::REG_INDEX_SCALE:      index_scale_cfg = val;
            hlcm_pkg::REG_X_LATTICE_STEP:   x_step_cfg      = val;
            hlcm_pkg::REG_Y_LATTICE_STEP:   y_step_cfg      = val;
            default: ;
        endcase
    endtask

    // input side: present queued particles, gaps between words
    always @(negedge i_clk) begin
        if (!i_s_axis_tvalid || word_taken) begin
            if (feed_gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                feed_gap--;
            end else if (particle_q.size() != 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= particle_q.pop_front();
                feed_gap = calm ? 0 : pick_gap();
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side: random back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(99) < 35) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        word_taken <= i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            expected_cells.push_back(migrate_cell(hlcm_pkg::t_pay'(i_s_axis_tdata)));
            words_in++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_out++;
            got = hlcm_pkg::t_pay'(o_m_axis_tdata);
            if (o_m_axis_tuser[hlcm_pkg::USER_MOVED]) moves_seen++;
            if (o_m_axis_tuser[hlcm_pkg::USER_FAR]) far_seen++;
            if (expected_cells.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual %h / %b",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
            end else begin
                want = expected_cells.pop_front();
                check_field("moved", want.moved, o_m_axis_tuser[hlcm_pkg::USER_MOVED]);
                check_field("far_jump", want.far, o_m_axis_tuser[hlcm_pkg::USER_FAR]);
                check_field("new_pos_x", want.pay.x, got.x);
                check_field("new_pos_y", want.pay.y, got.y);
                check_field("new_origin_x", want.pay.ox, got.ox);
                check_field("new_origin_y", want.pay.oy, got.oy);
                check_field("hops_out", want.pay.hops, got.hops);
            end
        end
    end

    // abort when no channel moves a word for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_cells.size());
            $display("hex_lattice_cell_migration_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int ph;
        int k;
        logic [hlcm_pkg::CFG_W-1:0] hh, sc, stx, sty;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (ph = 0; ph < PHASES; ph++) begin
            hh  = 31'd65536;
            sc  = 31'd65536;
            stx = 31'd65536;
            sty = 31'd65536;
            case (ph)
                1: begin
                    hh  = '0;
                    sc  = '1;
                    stx = '1;
                    sty = '1;
                end
                2: begin
                    hh  = '1;
                    sc  = '0;
                    stx = '0;
                    sty = '0;
                end
                3: begin
                    hh  = 31'd131072;
                    sc  = 31'd21845;
                    stx = 31'd98304;
                    sty = 31'd56756;
                end
                4, 5, 6: begin
                    hh  = 31'($urandom_range(1 << 20, 1 << 12));
                    sc  = 31'($urandom_range(1 << 18, 1 << 8));
                    stx = 31'($urandom_range(1 << 20, 1 << 10));
                    sty = 31'($urandom_range(1 << 20, 1 << 10));
                end
                7: begin
                    hh  = 31'($urandom());
                    sc  = 31'($urandom());
                    stx = 31'($urandom());
                    sty = 31'($urandom());
                end
                default: ;
            endcase
            if (ph != 0) begin
                write_reg(hlcm_pkg::REG_CELL_HALF_HEIGHT, hh);
                write_reg(hlcm_pkg::REG_INDEX_SCALE, sc);
                write_reg(hlcm_pkg::REG_X_LATTICE_STEP, stx);
                write_reg(hlcm_pkg::REG_Y_LATTICE_STEP, sty);
                @(negedge i_clk);
                i_cfg_valid <= 1'b0;
            end
            calm = (ph == 3) || (ph == 6);

            if (ph == 0) begin
                particle_q.push_back(particle(0, 0, 0, 0, 0));
                // largest projection right at the threshold, then just past it
                particle_q.push_back(particle(0, -32768, 0, 0, 7));
                particle_q.push_back(particle(0, -32769, 0, 0, 7));
                particle_q.push_back(particle(0, -65537, 0, 0, 7));
                particle_q.push_back(particle(0, 32769, ONE, -ONE, 100));
                particle_q.push_back(particle(ONE, 0, 0, 0, 1));
                particle_q.push_back(particle(-ONE, 0, 0, 0, 1));
                particle_q.push_back(particle(58982, 58982, 3 * ONE, 0, 2));
                particle_q.push_back(particle(-58982, -58982, 0, 3 * ONE, 2));
                particle_q.push_back(particle(39321, -39321, -ONE, ONE, 2));
                particle_q.push_back(particle(CMAX, CMAX, 0, 0, 9));
                particle_q.push_back(particle(CMIN, CMIN, 0, 0, 9));
                particle_q.push_back(particle(CMAX, CMIN, CMAX, CMIN, 9));
                particle_q.push_back(particle(CMIN, CMAX, CMIN, CMAX, 9));
                // shift pushes the cell centre past the rails
                particle_q.push_back(particle(5 * ONE, 3 * ONE, CMAX, CMAX, 3));
                particle_q.push_back(particle(-5 * ONE, -3 * ONE, CMIN, CMIN, 3));
                particle_q.push_back(particle(5 * ONE, -3 * ONE, CMIN, CMAX, 3));
                // hop count at and below its ceiling
                particle_q.push_back(particle(0, 2 * ONE, 0, 0, 65535));
                particle_q.push_back(particle(0, 2 * ONE, 0, 0, 65534));
                particle_q.push_back(particle(0, 0, 0, 0, 65535));
                particle_q.push_back(particle(0, 0, CMAX, CMIN, 65535));
                particle_q.push_back(particle(-1, -1, -1, -1, 65535));
            end
            for (k = 0; k < RANDOM_PER; k++)
                particle_q.push_back(random_particle());

            while (particle_q.size() != 0 || i_s_axis_tvalid || expected_cells.size() != 0)
                @(posedge i_clk);
        end

        // allow for any stray word still in the pipeline
        repeat (24) @(posedge i_clk);
        $display("%0d particles sent over %0d register settings, %0d results checked",
                 words_in, PHASES, results_out);
        $display("%0d migrations and %0d far jumps observed", moves_seen, far_seen);
        if (errors == 0 && expected_cells.size() == 0) begin
            $display("hex_lattice_cell_migration_tb: done, clean");
        end else begin
            $display("hex_lattice_cell_migration_tb: done, errors");
        end
        $finish;
    end

endmodule
